@@ hdl/gn3_pkg.sv @@
// Shared types and constants of the 3D gradient noise core.
// No dependencies; every other file of the core imports this package.
package gn3_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COORD_W     = 28;
    localparam int GRAD_W      = 16;
    localparam int OFF_W       = FRAC_BITS + 1;
    localparam int PROD_W      = OFF_W + GRAD_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int DOT_W       = SUM_W - (FRAC_BITS - 1);
    localparam int NOISE_W     = 16;

    localparam logic [1:0] OP_PERM = 2'd0;
    localparam logic [1:0] OP_GRAD = 2'd1;
    localparam logic [1:0] OP_EVAL = 2'd2;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic signed [GRAD_W-1:0] gz;
    } grad_t;

    typedef struct packed {
        logic [1:0]                op;
        logic [7:0]                entry_index;
        logic [7:0]                perm_value;
        grad_t                     grad;
        logic [2:0][COORD_W-1:0]   coord;
    } req_t;

    typedef struct packed {
        logic [1:0]                op;
        logic [IDX_W-1:0]          idx;
        logic [7:0]                perm_value;
        grad_t                     grad;
        logic [2:0][7:0]           lat;
        logic [2:0][7:0]           nxt;
        logic [2:0][FRAC_BITS-1:0] frac;
    } item_t;

    typedef struct packed {
        grad_t [7:0]               grad;
        logic [2:0][FRAC_BITS-1:0] frac;
        logic [2:0][FRAC_BITS-1:0] wgt;
    } dot_in_t;

    typedef struct packed {
        logic [7:0][DOT_W-1:0]     dot;
        logic [2:0][FRAC_BITS-1:0] wgt;
    } blend_in_t;

endpackage

@@ hdl/gn3_hash.sv @@
// Lattice cell, permutation hashing, gradient lookup and smoothstep weights.
// Three pipeline stages; uses gn3_pkg. Tables are replicated per read stage.
module gn3_hash import gn3_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] lattice_mask,
    input  logic       in_valid,
    output logic       in_ready,
    input  req_t       in_req,
    output logic       out_valid,
    input  logic       out_ready,
    output dot_in_t    out_data
);

    localparam logic [FRAC_BITS+1:0] TAIL_BASE = {2'b11, {FRAC_BITS{1'b0}}};

    // Each table copy is written at the stage where it is read, so writes and
    // reads stay in request order.
    logic [7:0] perm_a_mem [TABLE_DEPTH];
    logic [7:0] perm_b_mem [TABLE_DEPTH];
    logic [7:0] perm_c_mem [TABLE_DEPTH];
    grad_t      grad_mem   [4][TABLE_DEPTH];

    logic  v1_reg, v2_reg, v3_reg;
    logic  rdy1, rdy2, rdy3;
    item_t it0, it1_reg, it2_reg;
    logic [7:0] hx0_reg, hx1_reg;
    logic [7:0] h00_reg, h10_reg, h01_reg, h11_reg;
    logic [2:0][FRAC_BITS-1:0] sq_next, sq_reg;
    logic [2:0][FRAC_BITS+1:0] tail_next, tail_reg;
    logic [2:0][FRAC_BITS-1:0] wgt_next, wgt_reg, frac3_reg;
    logic [2*FRAC_BITS-1:0]    sq_prod [3];
    logic [2*FRAC_BITS+1:0]    w_prod [3];
    logic [IDX_W-1:0]          gaddr [8];
    grad_t [7:0]               gq_reg;

    function automatic logic [IDX_W-1:0] hidx(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] mask);
        logic [7:0] s;
        s = 8'(a + b) & mask;
        return IDX_W'(s);
    endfunction

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        it0.op         = in_req.op;
        it0.idx        = IDX_W'(in_req.entry_index);
        it0.perm_value = in_req.perm_value;
        it0.grad       = in_req.grad;
        for (int k = 0; k < 3; k++) begin
            it0.lat[k]  = 8'(in_req.coord[k] >> FRAC_BITS) & lattice_mask;
            it0.nxt[k]  = 8'(it0.lat[k] + 8'd1) & lattice_mask;
            it0.frac[k] = in_req.coord[k][FRAC_BITS-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq_prod[k]   = (2*FRAC_BITS)'(it1_reg.frac[k]) * (2*FRAC_BITS)'(it1_reg.frac[k]);
            sq_next[k]   = sq_prod[k][2*FRAC_BITS-1:FRAC_BITS];
            tail_next[k] = TAIL_BASE - {1'b0, it1_reg.frac[k], 1'b0};
            w_prod[k]    = (2*FRAC_BITS+2)'(sq_reg[k]) * (2*FRAC_BITS+2)'(tail_reg[k]);
            wgt_next[k]  = w_prod[k][2*FRAC_BITS-1:FRAC_BITS];
        end
    end

    // Corner c = x + 2y + 4z; the xy hash picks the row, z picks cell or next.
    always_comb begin
        logic [2:0] cb;
        logic [7:0] h;
        logic [7:0] zc;
        for (int c = 0; c < 8; c++) begin
            cb = 3'(c);
            case (cb[1:0])
                2'd0:    h = h00_reg;
                2'd1:    h = h10_reg;
                2'd2:    h = h01_reg;
                default: h = h11_reg;
            endcase
            zc       = cb[2] ? it2_reg.nxt[2] : it2_reg.lat[2];
            gaddr[c] = hidx(h, zc, lattice_mask);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg && (it2_reg.op == OP_EVAL);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && rdy1 && it0.op == OP_PERM) begin
            perm_a_mem[it0.idx] <= it0.perm_value;
        end
        if (rdy1) begin
            it1_reg <= it0;
            hx0_reg <= perm_a_mem[IDX_W'(it0.lat[0])];
            hx1_reg <= perm_a_mem[IDX_W'(it0.nxt[0])];
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && rdy2 && it1_reg.op == OP_PERM) begin
            perm_b_mem[it1_reg.idx] <= it1_reg.perm_value;
            perm_c_mem[it1_reg.idx] <= it1_reg.perm_value;
        end
        if (rdy2) begin
            it2_reg  <= it1_reg;
            h00_reg  <= perm_b_mem[hidx(hx0_reg, it1_reg.lat[1], lattice_mask)];
            h10_reg  <= perm_b_mem[hidx(hx1_reg, it1_reg.lat[1], lattice_mask)];
            h01_reg  <= perm_c_mem[hidx(hx0_reg, it1_reg.nxt[1], lattice_mask)];
            h11_reg  <= perm_c_mem[hidx(hx1_reg, it1_reg.nxt[1], lattice_mask)];
            sq_reg   <= sq_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 4; j++) begin
            if (v2_reg && rdy3 && it2_reg.op == OP_GRAD) begin
                grad_mem[j][it2_reg.idx] <= it2_reg.grad;
            end
            if (rdy3) begin
                gq_reg[2*j]   <= grad_mem[j][gaddr[2*j]];
                gq_reg[2*j+1] <= grad_mem[j][gaddr[2*j+1]];
            end
        end
        if (rdy3) begin
            frac3_reg <= it2_reg.frac;
            wgt_reg   <= wgt_next;
        end
    end

    assign out_valid     = v3_reg;
    assign out_data.grad = gq_reg;
    assign out_data.frac = frac3_reg;
    assign out_data.wgt  = wgt_reg;

endmodule

@@ hdl/gn3_dot.sv @@
// Eight corner dot products of gradient and offset, floored to Q.15.
// One pipeline stage; uses gn3_pkg.
module gn3_dot import gn3_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  dot_in_t   in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output blend_in_t out_data
);

    logic                       v_reg;
    logic [7:0][DOT_W-1:0]      dot_next, dot_reg;
    logic [2:0][FRAC_BITS-1:0]  wgt_reg;
    logic signed [OFF_W-1:0]    ox [8];
    logic signed [OFF_W-1:0]    oy [8];
    logic signed [OFF_W-1:0]    oz [8];
    logic signed [PROD_W-1:0]   px [8];
    logic signed [PROD_W-1:0]   py [8];
    logic signed [PROD_W-1:0]   pz [8];
    logic signed [SUM_W-1:0]    sum [8];

    assign in_ready = !v_reg || out_ready;

    // The far-corner offset f - 1.0 is just the fraction with the sign bit set.
    always_comb begin
        logic [2:0] cb;
        for (int c = 0; c < 8; c++) begin
            cb          = 3'(c);
            ox[c]       = $signed({cb[0], in_data.frac[0]});
            oy[c]       = $signed({cb[1], in_data.frac[1]});
            oz[c]       = $signed({cb[2], in_data.frac[2]});
            px[c]       = ox[c] * in_data.grad[c].gx;
            py[c]       = oy[c] * in_data.grad[c].gy;
            pz[c]       = oz[c] * in_data.grad[c].gz;
            sum[c]      = SUM_W'(px[c]) + SUM_W'(py[c]) + SUM_W'(pz[c]);
            dot_next[c] = sum[c][SUM_W-1:FRAC_BITS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            dot_reg <= dot_next;
            wgt_reg <= in_data.wgt;
        end
    end

    assign out_valid    = v_reg;
    assign out_data.dot = dot_reg;
    assign out_data.wgt = wgt_reg;

endmodule

@@ hdl/gn3_blend.sv @@
// Trilinear blend of the corner dots along x, y and z, then saturation.
// Three pipeline stages, the last one being the output register; uses gn3_pkg.
module gn3_blend import gn3_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  blend_in_t                 in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [NOISE_W-1:0] out_value
);

    localparam logic signed [DOT_W-1:0] SAT_HI = DOT_W'(32767);
    localparam logic signed [DOT_W-1:0] SAT_LO = -DOT_W'(32768);

    logic v5_reg, v6_reg, v7_reg;
    logic rdy5, rdy6, rdy7;
    logic [3:0][DOT_W-1:0] e_next, e_reg;
    logic [1:0][DOT_W-1:0] l_next, l_reg;
    logic [FRAC_BITS-1:0]  wy5_reg, wz5_reg, wz6_reg;
    logic signed [DOT_W-1:0]   r_next;
    logic signed [NOISE_W-1:0] sat_next, out_reg;

    // a + floor(w * (b - a)); the result stays between a and b.
    function automatic logic [DOT_W-1:0] mix(input logic [FRAC_BITS-1:0] w,
                                             input logic [DOT_W-1:0] a,
                                             input logic [DOT_W-1:0] b);
        logic signed [DOT_W:0]             diff;
        logic signed [FRAC_BITS+DOT_W+1:0] prod;
        logic [DOT_W:0]                    s;
        diff = $signed({b[DOT_W-1], b}) - $signed({a[DOT_W-1], a});
        prod = $signed({1'b0, w}) * diff;
        s    = {a[DOT_W-1], a} + prod[FRAC_BITS+DOT_W:FRAC_BITS];
        return s[DOT_W-1:0];
    endfunction

    assign rdy7     = !v7_reg || out_ready;
    assign rdy6     = !v6_reg || rdy7;
    assign rdy5     = !v5_reg || rdy6;
    assign in_ready = rdy5;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            e_next[j] = mix(in_data.wgt[0], in_data.dot[2*j], in_data.dot[2*j+1]);
        end
        for (int k = 0; k < 2; k++) begin
            l_next[k] = mix(wy5_reg, e_reg[2*k], e_reg[2*k+1]);
        end
        r_next = $signed(mix(wz6_reg, l_reg[0], l_reg[1]));
        if (r_next > SAT_HI) begin
            sat_next = 16'sh7fff;
        end else if (r_next < SAT_LO) begin
            sat_next = 16'sh8000;
        end else begin
            sat_next = r_next[NOISE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (rdy5) v5_reg <= in_valid;
            if (rdy6) v6_reg <= v5_reg;
            if (rdy7) v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            e_reg   <= e_next;
            wy5_reg <= in_data.wgt[1];
            wz5_reg <= in_data.wgt[2];
        end
        if (rdy6) begin
            l_reg   <= l_next;
            wz6_reg <= wz5_reg;
        end
        if (rdy7) begin
            out_reg <= sat_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_value = out_reg;

endmodule

@@ hdl/gradient_noise_3d_core.sv @@
// 3D gradient noise core: one request per clock in and one noise sample per clock out
// while m_ready stays high, seven register stages. Requests of op 0 and 1 load the
// permutation and gradient tables, pass in order through the hash stages and give no result;
// both tables must be loaded before the first evaluate. The lattice mask may be changed
// only while the pipeline is empty. The seven stages are: permutation lookup of x, hashing
// with y, gradient lookup and weights, dot products, then blends along x, y and z.
module gradient_noise_3d_core import gn3_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      lattice_mask_we,
    input  logic [7:0]                lattice_mask_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_op,
    input  logic [7:0]                s_entry_index,
    input  logic [7:0]                s_perm_value,
    input  logic signed [GRAD_W-1:0]  s_grad_x,
    input  logic signed [GRAD_W-1:0]  s_grad_y,
    input  logic signed [GRAD_W-1:0]  s_grad_z,
    input  logic [COORD_W-1:0]        s_coord_x,
    input  logic [COORD_W-1:0]        s_coord_y,
    input  logic [COORD_W-1:0]        s_coord_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [NOISE_W-1:0] m_noise_value
);

    logic [7:0] mask_reg;
    req_t       req;
    logic       hd_valid, hd_ready, db_valid, db_ready;
    dot_in_t    hd_data;
    blend_in_t  db_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 8'hff;
        end else if (lattice_mask_we) begin
            mask_reg <= lattice_mask_wdata;
        end
    end

    assign req.op          = s_op;
    assign req.entry_index = s_entry_index;
    assign req.perm_value  = s_perm_value;
    assign req.grad.gx     = s_grad_x;
    assign req.grad.gy     = s_grad_y;
    assign req.grad.gz     = s_grad_z;
    assign req.coord[0]    = s_coord_x;
    assign req.coord[1]    = s_coord_y;
    assign req.coord[2]    = s_coord_z;

    gn3_hash u_hash (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .lattice_mask (mask_reg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_req       (req),
        .out_valid    (hd_valid),
        .out_ready    (hd_ready),
        .out_data     (hd_data)
    );

    gn3_dot u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (hd_valid),
        .in_ready  (hd_ready),
        .in_data   (hd_data),
        .out_valid (db_valid),
        .out_ready (db_ready),
        .out_data  (db_data)
    );

    gn3_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (db_valid),
        .in_ready  (db_ready),
        .in_data   (db_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_value (m_noise_value)
    );

endmodule

@@ verif/tb_gradient_noise_3d_core.sv @@
// Self-checking testbench for gradient_noise_3d_core: table loads, directed and random evaluates.
// Depends on gn3_pkg and the core; expected samples come from a predictor kept in this file.
`timescale 1ns / 1ps

module tb_gradient_noise_3d_core;
    import gn3_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         DRAIN_CYCLES = 12;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  idx;
        logic [7:0]  pv;
        shortint     gx, gy, gz;
        logic [27:0] cx, cy, cz;
        bit          typed;
        shortint     typed_val;
    } stim_row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      lattice_mask_we;
    logic [7:0]                lattice_mask_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic [1:0]                s_op;
    logic [7:0]                s_entry_index;
    logic [7:0]                s_perm_value;
    logic signed [GRAD_W-1:0]  s_grad_x, s_grad_y, s_grad_z;
    logic [COORD_W-1:0]        s_coord_x, s_coord_y, s_coord_z;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [NOISE_W-1:0] m_noise_value;

    // Shadow copy of the tables and the mask.
    logic [7:0] perm_shadow [256];
    shortint    gx_shadow [256];
    shortint    gy_shadow [256];
    shortint    gz_shadow [256];
    logic [7:0] mask_shadow;

    shortint    noise_expected [$];
    stim_row_t  dir_rows [$];
    int         error_count;
    int         eval_count;
    int         write_count;
    int         burst_left;
    int         cycle_count;

    gradient_noise_3d_core DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .lattice_mask_we    (lattice_mask_we),
        .lattice_mask_wdata (lattice_mask_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_entry_index      (s_entry_index),
        .s_perm_value       (s_perm_value),
        .s_grad_x           (s_grad_x),
        .s_grad_y           (s_grad_y),
        .s_grad_z           (s_grad_z),
        .s_coord_x          (s_coord_x),
        .s_coord_y          (s_coord_y),
        .s_coord_z          (s_coord_z),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_noise_value      (m_noise_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint smooth_weight(longint f);
        longint sq;
        sq = (f * f) >> FRAC_BITS;
        return (sq * ((longint'(3) << FRAC_BITS) - 2 * f)) >> FRAC_BITS;
    endfunction

    function automatic longint blend(longint w, longint a, longint b);
        return a + ((w * (b - a)) >>> FRAC_BITS);
    endfunction

    function automatic longint corner_dot(longint gi, longint ox, longint oy, longint oz);
        longint i;
        i = gi & longint'(mask_shadow);
        return (ox * gx_shadow[i] + oy * gy_shadow[i] + oz * gz_shadow[i]) >>> (FRAC_BITS - 1);
    endfunction

    function automatic shortint noise_predict(logic [27:0] cx, logic [27:0] cy, logic [27:0] cz);
        logic [27:0] c [3];
        longint lat [3], nxt [3], o0 [3], o1 [3], w [3];
        longint m, hx0, hx1, h00, h10, h01, h11, lo, hi, e0, e1, r;
        c = '{cx, cy, cz};
        m = mask_shadow;
        for (int k = 0; k < 3; k++) begin
            lat[k] = (c[k] >> FRAC_BITS) & m;
            nxt[k] = (lat[k] + 1) & m;
            o0[k]  = c[k] & ((1 << FRAC_BITS) - 1);
            o1[k]  = o0[k] - (longint'(1) << FRAC_BITS);
            w[k]   = smooth_weight(o0[k]);
        end
        hx0 = perm_shadow[lat[0]];
        hx1 = perm_shadow[nxt[0]];
        h00 = perm_shadow[(hx0 + lat[1]) & m];
        h10 = perm_shadow[(hx1 + lat[1]) & m];
        h01 = perm_shadow[(hx0 + nxt[1]) & m];
        h11 = perm_shadow[(hx1 + nxt[1]) & m];
        e0 = blend(w[0], corner_dot(h00 + lat[2], o0[0], o0[1], o0[2]),
                         corner_dot(h10 + lat[2], o1[0], o0[1], o0[2]));
        e1 = blend(w[0], corner_dot(h01 + lat[2], o0[0], o1[1], o0[2]),
                         corner_dot(h11 + lat[2], o1[0], o1[1], o0[2]));
        lo = blend(w[1], e0, e1);
        e0 = blend(w[0], corner_dot(h00 + nxt[2], o0[0], o0[1], o1[2]),
                         corner_dot(h10 + nxt[2], o1[0], o0[1], o1[2]));
        e1 = blend(w[0], corner_dot(h01 + nxt[2], o0[0], o1[1], o1[2]),
                         corner_dot(h11 + nxt[2], o1[0], o1[1], o1[2]));
        hi = blend(w[1], e0, e1);
        r  = blend(w[2], lo, hi);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return shortint'(r);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Sends one request with burst/gap pacing and updates the shadow state on acceptance.
    task automatic send_request(stim_row_t row);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_op          <= row.op;
        s_entry_index <= row.idx;
        s_perm_value  <= row.pv;
        s_grad_x      <= row.gx;
        s_grad_y      <= row.gy;
        s_grad_z      <= row.gz;
        s_coord_x     <= row.cx;
        s_coord_y     <= row.cy;
        s_coord_z     <= row.cz;
        do @(posedge aclk); while (!s_ready);
        case (row.op)
            OP_PERM: begin
                perm_shadow[row.idx] = row.pv;
                write_count++;
            end
            OP_GRAD: begin
                gx_shadow[row.idx] = row.gx;
                gy_shadow[row.idx] = row.gy;
                gz_shadow[row.idx] = row.gz;
                write_count++;
            end
            OP_EVAL: begin
                noise_expected.push_back(row.typed ? row.typed_val
                                                   : noise_predict(row.cx, row.cy, row.cz));
                eval_count++;
            end
            default: ;
        endcase
    endtask

    // Pauses the sender until every pending sample has come back and the pipeline is empty.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (noise_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mask(logic [7:0] value);
        lattice_mask_we    <= 1'b1;
        lattice_mask_wdata <= value;
        @(posedge aclk);
        lattice_mask_we <= 1'b0;
        mask_shadow = value;
    endtask

    function automatic shortint rand_grad();
        return shortint'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic stim_row_t make_row(logic [1:0] op, logic [7:0] idx, logic [7:0] pv,
                                           shortint gx, shortint gy, shortint gz,
                                           logic [27:0] cx, logic [27:0] cy, logic [27:0] cz,
                                           bit typed, shortint typed_val);
        stim_row_t r;
        r = '{op, idx, pv, gx, gy, gz, cx, cy, cz, typed, typed_val};
        return r;
    endfunction

    function automatic logic [27:0] rand_coord();
        logic [27:0] c;
        c = 28'($urandom());
        case ($urandom_range(0, 5))
            0: c[15:0] = 16'h0000;
            1: c[15:0] = 16'hFFFF;
            2: c[27:16] = 12'($urandom_range(0, 3));
            default: ;
        endcase
        return c;
    endfunction

    function automatic stim_row_t rand_row();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return make_row(OP_PERM, 8'($urandom()), 8'($urandom()), 0, 0, 0, 0, 0, 0, 0, 0);
        if (pick < 12)
            return make_row(OP_GRAD, 8'($urandom()), 0, rand_grad(), rand_grad(), rand_grad(),
                            0, 0, 0, 0, 0);
        if (pick < 15)
            return make_row(OP_UNUSED, 8'($urandom()), 8'($urandom()), rand_grad(), rand_grad(),
                            rand_grad(), rand_coord(), rand_coord(), rand_coord(), 0, 0);
        return make_row(OP_EVAL, 8'($urandom()), 8'($urandom()), rand_grad(), rand_grad(),
                        rand_grad(), rand_coord(), rand_coord(), rand_coord(), 0, 0);
    endfunction

    // Receiver alternates between always ready, random stalls and long stalls.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count >> 6) % 3)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (noise_expected.size() == 0) begin
                report_mismatch("unexpected sample", m_noise_value, 0);
            end else begin
                if (m_noise_value !== noise_expected[0])
                    report_mismatch("noise_value", m_noise_value, noise_expected[0]);
                void'(noise_expected.pop_front());
            end
        end
    end

    initial begin
        logic [7:0] mask_list [6];
        logic [7:0] perm_init [256];
        mask_list = '{8'd1, 8'd0, 8'd128, 8'd15, 8'd3, 8'd255};
        error_count = 0;
        eval_count  = 0;
        write_count = 0;
        burst_left  = 0;
        mask_shadow = 8'd255;
        aresetn            <= 1'b0;
        lattice_mask_we    <= 1'b0;
        lattice_mask_wdata <= 8'd0;
        s_valid            <= 1'b0;
        s_op               <= OP_PERM;
        s_entry_index      <= '0;
        s_perm_value       <= '0;
        s_grad_x           <= '0;
        s_grad_y           <= '0;
        s_grad_z           <= '0;
        s_coord_x          <= '0;
        s_coord_y          <= '0;
        s_coord_z          <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Both tables are filled completely before the first evaluate.
        for (int i = 0; i < 256; i++) perm_init[i] = 8'(i);
        perm_init.shuffle();
        for (int i = 0; i < 256; i++) begin
            send_request(make_row(OP_PERM, 8'(i), perm_init[i], 0, 0, 0, 0, 0, 0, 0, 0));
            send_request(make_row(OP_GRAD, 8'(i), 0, rand_grad(), rand_grad(), rand_grad(),
                                  0, 0, 0, 0, 0));
        end

        // Directed rows; samples at lattice points are zero whatever the tables hold.
        dir_rows.push_back(make_row(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        dir_rows.push_back(make_row(OP_EVAL, 0, 0, 0, 0, 0, 28'h0050000, 28'h0090000,
                                    28'h0C80000, 1, 0));
        dir_rows.push_back(make_row(OP_EVAL, 0, 0, 0, 0, 0, 28'hFFF0000, 28'hFFF0000,
                                    28'hFFF0000, 1, 0));
        dir_rows.push_back(make_row(OP_EVAL, 0, 0, 0, 0, 0, 28'hFFFFFFF, 28'hFFFFFFF,
                                    28'hFFFFFFF, 0, 0));
        dir_rows.push_back(make_row(OP_EVAL, 0, 0, 0, 0, 0, 28'h0008000, 28'h0008000,
                                    28'h0008000, 0, 0));
        dir_rows.push_back(make_row(OP_UNUSED, 8'hFF, 8'hFF, -16384, 16384, -1,
                                    28'hFFFFFFF, 28'h1234567, 28'h0008000, 0, 0));
        dir_rows.push_back(make_row(OP_PERM, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_PERM, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_GRAD, 8'hFF, 0, 16384, 16384, 16384, 0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_GRAD, 8'h00, 0, -16384, -16384, -16384,
                                    0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_GRAD, 8'h80, 0, 16384, -16384, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_EVAL, 0, 0, 0, 0, 0, 28'h000FFFF, 0, 0, 0, 0));
        dir_rows.push_back(make_row(OP_EVAL, 0, 0, 0, 0, 0, 28'h0FFFFFF, 28'h0FFFFFF,
                                    28'h0FFFFFF, 0, 0));
        dir_rows.push_back(make_row(OP_EVAL, 0, 0, 0, 0, 0, 28'h00F8000, 28'h0FF4000,
                                    28'h000C000, 0, 0));
        dir_rows.push_back(make_row(OP_EVAL, 0, 0, 0, 0, 0, 28'h0000001, 28'h000FFFE,
                                    28'hAAA5555, 0, 0));
        foreach (dir_rows[i]) send_request(dir_rows[i]);
        drain_pipeline();

        foreach (mask_list[m]) begin
            write_mask(mask_list[m]);
            repeat (20) send_request(rand_row());
            drain_pipeline();
        end

        $display("Covered %0d table writes and %0d noise samples over six lattice masks,",
                 write_count, eval_count);
        $display("with sender gaps, receiver stalls and unused op codes mixed in.");
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
